// ----- hdl/accel_tilt_angles_assert.svh -----
// Assertion macros for the accel_tilt_angles block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH
`ifndef ASSERT_OFF
`define ATA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ATA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ATA_ASSERT(lbl, clk, rst, prop, msg)
`define ATA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/ata_pkg.sv -----
// Shared constants, types and the arctangent table of the tilt angle pipeline.
// No dependencies; imported by every module of the block.
package ata_pkg;

  // Vectoring steps; more than the table holds act as the table length
  localparam int CORDIC_STEPS = 16;
  localparam int TBL_LEN      = 24;
  localparam int N_ITER       = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;

  // Root of (y*y + z*z) * 2^32: 32 root bits, one per stage
  localparam int SQRT_BITS = 32;
  localparam int REM_W     = SQRT_BITS + 3;

  // Vector and angle widths; angle counts 2^-15 degree
  localparam int CW       = 35;
  localparam int AW       = 25;
  localparam int IN_SHIFT = 16;

  localparam logic signed [AW-1:0] ANG_90  = AW'(2949120);
  localparam logic signed [AW-1:0] ANG_180 = AW'(5898240);

  // atan(2^-i) in 2^-15 degree
  localparam logic signed [AW-1:0] ATAN_TBL [TBL_LEN] = '{
    AW'(1474560), AW'(870484), AW'(459940), AW'(233473),
    AW'(117189),  AW'(58652),  AW'(29333),  AW'(14667),
    AW'(7334),    AW'(3667),   AW'(1833),   AW'(917),
    AW'(458),     AW'(229),    AW'(115),    AW'(57),
    AW'(29),      AW'(14),     AW'(7),      AW'(4),
    AW'(2),       AW'(1),      AW'(0),      AW'(0)
  };

  // Output rounding to 1/128 degree
  localparam int ROUND_HALF = 128;
  localparam int FRAC_SHIFT = 8;
  localparam int PITCH_LIM  = 11520;
  localparam int ROLL_LIM   = 23040;

  // Register stages from accepted beat to result strobe
  localparam int LATENCY = 4 + SQRT_BITS + N_ITER;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } side_t;

endpackage

// ----- hdl/ata_isqrt_pipe.sv -----
// Pipelined restoring square root: floor(sqrt(s * 2^32)), one root bit per stage.
// Depends on ata_pkg; carries the raw sample alongside as a side struct.
module ata_isqrt_pipe import ata_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [SQRT_BITS-1:0] in_s,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [SQRT_BITS-1:0] out_root,
  output side_t                out_side
);

  logic                 vld  [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] sv   [SQRT_BITS+1];
  logic [REM_W-1:0]     rem  [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] root [SQRT_BITS+1];
  side_t                side [SQRT_BITS+1];

  assign vld[0]  = in_vld;
  assign sv[0]   = in_s;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
    localparam int K = SQRT_BITS - 1 - j;
    logic [2*SQRT_BITS-1:0] n_full;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       trial;
    logic                   fits;

    // bring down the next two radicand bits and try a one
    always_comb begin
      n_full = {sv[j], SQRT_BITS'(0)};
      rem_sh = {rem[j][REM_W-3:0], n_full[2*K+1 -: 2]};
      trial  = {{(REM_W-SQRT_BITS-2){1'b0}}, root[j], 2'b01};
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      sv[j+1]   <= sv[j];
      rem[j+1]  <= fits ? (rem_sh - trial) : rem_sh;
      root[j+1] <= {root[j][SQRT_BITS-2:0], fits};
      side[j+1] <= side[j];
    end
  end

  assign out_vld  = vld[SQRT_BITS];
  assign out_root = root[SQRT_BITS];
  assign out_side = side[SQRT_BITS];

endmodule

// ----- hdl/ata_cordic_pipe.sv -----
// Vectoring CORDIC pipeline: angle of (a, b) in 2^-15 degree, -180..+180.
// Depends on ata_pkg for widths, step count and the arctangent table.
module ata_cordic_pipe import ata_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] in_a,
  input  logic signed [CW-1:0] in_b,
  output logic                 out_vld,
  output logic signed [AW-1:0] out_ang
);

  logic                 vld [N_ITER+1];
  logic                 fix [N_ITER+1];
  logic signed [CW-1:0] av  [N_ITER+1];
  logic signed [CW-1:0] bv  [N_ITER+1];
  logic signed [AW-1:0] ang [N_ITER+1];

  logic                 pre_fix;
  logic signed [CW-1:0] pre_a;
  logic signed [CW-1:0] pre_b;
  logic signed [AW-1:0] pre_ang;

  // exact answers on the axes, quarter turn from the left into the right half-plane
  always_comb begin
    pre_fix = 1'b0;
    pre_a   = in_a;
    pre_b   = in_b;
    pre_ang = '0;
    priority if (in_b == '0) begin
      pre_fix = 1'b1;
      pre_ang = (in_a < 0) ? ANG_180 : AW'(0);
    end else if (in_a == '0) begin
      pre_fix = 1'b1;
      pre_ang = (in_b > 0) ? ANG_90 : -ANG_90;
    end else if (in_a < 0) begin
      if (in_b >= 0) begin
        pre_a   = in_b;
        pre_b   = -in_a;
        pre_ang = ANG_90;
      end else begin
        pre_a   = -in_b;
        pre_b   = in_a;
        pre_ang = -ANG_90;
      end
    end else begin
      // right half-plane: pass the vector straight to the iterations
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    fix[0] <= pre_fix;
    av[0]  <= pre_a;
    bv[0]  <= pre_b;
    ang[0] <= pre_ang;
  end

  for (genvar j = 0; j < N_ITER; j++) begin : g_iter
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;

    assign da = bv[j] >>> j;
    assign db = av[j] >>> j;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      fix[j+1] <= fix[j];
      if (fix[j]) begin
        av[j+1]  <= av[j];
        bv[j+1]  <= bv[j];
        ang[j+1] <= ang[j];
      end else if (bv[j] >= 0) begin
        av[j+1]  <= av[j] + da;
        bv[j+1]  <= bv[j] - db;
        ang[j+1] <= ang[j] + ATAN_TBL[j];
      end else begin
        av[j+1]  <= av[j] - da;
        bv[j+1]  <= bv[j] + db;
        ang[j+1] <= ang[j] - ATAN_TBL[j];
      end
    end
  end

  assign out_vld = vld[N_ITER];
  assign out_ang = ang[N_ITER];

endmodule

// ----- hdl/accel_tilt_angles.sv -----
// Tilt angles (pitch, roll) from one raw three-axis accelerometer sample.
// Register stages from accepted beat to done: LATENCY = 4 + 32 + N_ITER.
// Throughput: one sample per cycle; the 32-stage root pipeline and the unrolled
// CORDIC stages each hold one beat, so busy never rises outside reset.
// Reset: synchronous, active high; clears every valid bit, busy is high during it.
// The receiver cannot stall: each result shows for one cycle with done high.
`include "accel_tilt_angles_assert.svh"
module accel_tilt_angles import ata_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               done,
  output logic signed [14:0] pitch,
  output logic signed [15:0] roll
);

  // Beats are refused only while reset holds the pipeline
  logic take;
  assign busy = rst;
  assign take = start && !busy;

  // ---- Stage 1: lateral squares ----
  logic signed [31:0] yy_prod;
  logic signed [31:0] zz_prod;
  logic               sq_vld;
  logic [30:0]        yy;
  logic [30:0]        zz;
  side_t              sq_side;

  // each square is at most 2^30, so bit 31 is always clear
  assign yy_prod = accel_y * accel_y;
  assign zz_prod = accel_z * accel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= take;
    end
    yy      <= yy_prod[30:0];
    zz      <= zz_prod[30:0];
    sq_side <= '{x: accel_x, y: accel_y, z: accel_z};
  end

  // ---- Stage 2: sum of squares ----
  logic                 sum_vld;
  logic [SQRT_BITS-1:0] sum_s;
  side_t                sum_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= sq_vld;
    end
    sum_s    <= SQRT_BITS'({1'b0, yy} + {1'b0, zz});
    sum_side <= sq_side;
  end

  // ---- Root of the lateral magnitude, 16 fraction bits ----
  logic                 rt_vld;
  logic [SQRT_BITS-1:0] rt_root;
  side_t                rt_side;

  ata_isqrt_pipe u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sum_vld),
    .in_s     (sum_s),
    .in_side  (sum_side),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // ---- Both CORDIC lanes start together ----
  // Pitch vector is (r, -x * 2^16). With y = z = 0 the root is zero and the
  // axis cases in the CORDIC already give 0 or +/-90 degrees by the sign of -x.
  // Roll vector is (z * 2^16, y * 2^16).
  logic signed [CW-1:0] xe, ye, ze;
  logic signed [CW-1:0] p_a, p_b, r_a, r_b;

  assign xe  = CW'(rt_side.x);
  assign ye  = CW'(rt_side.y);
  assign ze  = CW'(rt_side.z);
  assign p_a = $signed({{(CW-SQRT_BITS){1'b0}}, rt_root});
  assign p_b = -(xe <<< IN_SHIFT);
  assign r_a = ze <<< IN_SHIFT;
  assign r_b = ye <<< IN_SHIFT;

  logic                 p_vld, r_vld;
  logic signed [AW-1:0] p_ang, r_ang;

  ata_cordic_pipe u_cordic_pitch (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rt_vld),
    .in_a    (p_a),
    .in_b    (p_b),
    .out_vld (p_vld),
    .out_ang (p_ang)
  );

  ata_cordic_pipe u_cordic_roll (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rt_vld),
    .in_a    (r_a),
    .in_b    (r_b),
    .out_vld (r_vld),
    .out_ang (r_ang)
  );

  // ---- Output stage: round halves upward to 1/128 degree, then clamp ----
  // The residual of the last step can land just beyond the range ends.
  logic signed [AW:0] p_rnd, r_rnd;
  logic signed [AW:0] p_sat, r_sat;

  always_comb begin
    p_rnd = ($signed({p_ang[AW-1], p_ang}) + (AW+1)'(ROUND_HALF)) >>> FRAC_SHIFT;
    r_rnd = ($signed({r_ang[AW-1], r_ang}) + (AW+1)'(ROUND_HALF)) >>> FRAC_SHIFT;

    priority if (p_rnd > (AW+1)'(PITCH_LIM)) begin
      p_sat = (AW+1)'(PITCH_LIM);
    end else if (p_rnd < -(AW+1)'(PITCH_LIM)) begin
      p_sat = -(AW+1)'(PITCH_LIM);
    end else begin
      p_sat = p_rnd;
    end

    priority if (r_rnd > (AW+1)'(ROLL_LIM)) begin
      r_sat = (AW+1)'(ROLL_LIM);
    end else if (r_rnd < -(AW+1)'(ROLL_LIM)) begin
      r_sat = -(AW+1)'(ROLL_LIM);
    end else begin
      r_sat = r_rnd;
    end
  end

  // Drive the strobe for one cycle per beat; hold the angles until the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_vld;
    end
    if (p_vld) begin
      pitch <= 15'(p_sat);
      roll  <= 16'(r_sat);
    end
  end

  // ---- Checks ----
  `ATA_ASSERT(a_lanes_aligned, clk, rst, p_vld == r_vld, "pitch and roll lanes out of step")
  `ATA_ASSERT_IMP(a_latency, clk, rst, done, $past(take, LATENCY), "result without a beat")
  `ATA_ASSERT_IMP(a_pitch_range, clk, rst, done, (pitch <= 15'sd11520) && (pitch >= -15'sd11520), "pitch out of range")
  `ATA_ASSERT_IMP(a_roll_range, clk, rst, done, (roll <= 16'sd23040) && (roll >= -16'sd23040), "roll out of range")

endmodule
